[rtl/afrf_pkg.sv]
// ---------------------------------------------------------------------------
// afrf_pkg: shared types and constants of the audio frame ring fifo
// Operation codes, controller states and the result flag group.
// ---------------------------------------------------------------------------
`default_nettype none

package afrf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int LEVEL_W  = 12;
    localparam int CHAN_W   = 2;
    localparam int FUNC_W   = 2;

    localparam logic [CHAN_W-1:0] CHAN_MONO  = 2'd1;
    localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_FINISH = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EMIT = 1'b1
    } state_t;

    typedef struct packed {
        logic stream_ended;
        logic write_dropped;
        logic frame_valid;
    } res_flags_t;

endpackage

`default_nettype wire

[rtl/afrf_mem.sv]
// ---------------------------------------------------------------------------
// afrf_mem: sample store
// One write port and two read ports, read data registered.
// ---------------------------------------------------------------------------
`default_nettype none

module afrf_mem #(
    parameter int DEPTH = 4096
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [$clog2(DEPTH)-1:0]   waddr,
    input  wire afrf_pkg::sample_t          wdata,
    input  wire logic                       re,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr0,
    input  wire logic [$clog2(DEPTH)-1:0]   raddr1,
    output afrf_pkg::sample_t               rdata0,
    output afrf_pkg::sample_t               rdata1
);
    import afrf_pkg::*;

    sample_t store [DEPTH];
    sample_t rdata0_reg;
    sample_t rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata0_reg <= store[raddr0];
            rdata1_reg <= store[raddr1];
        end
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

`default_nettype wire

[rtl/afrf_ctrl.sv]
// ---------------------------------------------------------------------------
// afrf_ctrl: pointer and handshake control
// Keeps the ring pointers, finished mark and channel count, drives the
// sample store and holds the result in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module afrf_ctrl #(
    parameter int DEPTH = 4096
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // config channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [afrf_pkg::CHAN_W-1:0]       cfg_data,
    // input transaction
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire afrf_pkg::func_t                   in_func,
    input  wire afrf_pkg::sample_t                 in_sample,
    // sample store
    output logic                                   mem_we,
    output logic [$clog2(DEPTH)-1:0]               mem_waddr,
    output afrf_pkg::sample_t                      mem_wdata,
    output logic                                   mem_re,
    output logic [$clog2(DEPTH)-1:0]               mem_raddr0,
    output logic [$clog2(DEPTH)-1:0]               mem_raddr1,
    input  wire afrf_pkg::sample_t                 mem_rdata0,
    input  wire afrf_pkg::sample_t                 mem_rdata1,
    // result transaction
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output afrf_pkg::sample_t                      out_left,
    output afrf_pkg::sample_t                      out_right,
    output afrf_pkg::res_flags_t                   out_flags,
    output logic [afrf_pkg::LEVEL_W-1:0]           out_fill,
    output logic [afrf_pkg::LEVEL_W-1:0]           out_free
);
    import afrf_pkg::*;

    localparam int PW = $clog2(DEPTH);

    state_t             state_reg, state_next;
    logic [PW-1:0]      wp_reg, wp_next;
    logic [PW-1:0]      rp_reg, rp_next;
    logic               fin_reg, fin_next;
    logic [CHAN_W-1:0]  chan_reg;

    res_flags_t         pend_flags_reg, pend_flags_next;
    logic               pend_stereo_reg;
    logic [LEVEL_W-1:0] pend_fill_reg, pend_fill_next;
    logic [LEVEL_W-1:0] pend_free_reg, pend_free_next;

    logic               out_valid_reg;
    sample_t            out_left_reg;
    sample_t            out_right_reg;
    res_flags_t         out_flags_reg;
    logic [LEVEL_W-1:0] out_fill_reg;
    logic [LEVEL_W-1:0] out_free_reg;

    logic               accept;
    logic               emit;
    logic               mono;
    logic [PW-1:0]      fill_now;
    logic [PW-1:0]      fill_after;
    logic               full;
    logic               frame_ready;
    logic               ended;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign emit      = (state_reg == ST_EMIT) && (!out_valid_reg || out_ready);

    assign mono      = (chan_reg == CHAN_MONO);
    assign fill_now  = wp_reg - rp_reg;
    // ring holds at most DEPTH-1 samples
    assign full      = &fill_now;
    assign frame_ready = mono ? (fill_now != '0) : (fill_now[PW-1:1] != '0);

    always_comb
    begin
        wp_next         = wp_reg;
        rp_next         = rp_reg;
        fin_next        = fin_reg;
        pend_flags_next = '0;
        mem_we          = 1'b0;
        mem_waddr       = wp_reg;
        mem_wdata       = in_sample;
        mem_re          = accept;
        mem_raddr0      = rp_reg;
        mem_raddr1      = rp_reg + PW'(1);
        if (accept)
        begin
            unique case (in_func)
                FUNC_PUSH:
                begin
                    if (full)
                    begin
                        pend_flags_next.write_dropped = 1'b1;
                    end
                    else
                    begin
                        mem_we  = 1'b1;
                        wp_next = wp_reg + PW'(1);
                    end
                end
                FUNC_POP:
                begin
                    if (frame_ready)
                    begin
                        pend_flags_next.frame_valid = 1'b1;
                        rp_next = mono ? rp_reg + PW'(1) : rp_reg + PW'(2);
                    end
                end
                FUNC_FINISH:
                begin
                    fin_next = 1'b1;
                end
                FUNC_CLEAR:
                begin
                    wp_next  = '0;
                    rp_next  = '0;
                    fin_next = 1'b0;
                end
                default:
                begin
                    wp_next = wp_reg;
                end
            endcase
        end
        fill_after = wp_next - rp_next;
        ended = fin_next && (mono ? (fill_after == '0) : (fill_after[PW-1:1] == '0));
        pend_flags_next.stream_ended = ended;
        pend_fill_next = LEVEL_W'(fill_after);
        pend_free_next = LEVEL_W'(~fill_after);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            rp_reg        <= '0;
            fin_reg       <= 1'b0;
            chan_reg      <= CHAN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            fin_reg   <= fin_next;
            if (cfg_valid && cfg_ready)
            begin
                chan_reg <= cfg_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result bookkeeping, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_flags_reg  <= pend_flags_next;
            pend_stereo_reg <= !mono;
            pend_fill_reg   <= pend_fill_next;
            pend_free_reg   <= pend_free_next;
        end
        if (emit)
        begin
            out_left_reg  <= pend_flags_reg.frame_valid ? mem_rdata0 : '0;
            out_right_reg <= (pend_flags_reg.frame_valid && pend_stereo_reg) ?
                             mem_rdata1 : '0;
            out_flags_reg <= pend_flags_reg;
            out_fill_reg  <= pend_fill_reg;
            out_free_reg  <= pend_free_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;
    assign out_flags = out_flags_reg;
    assign out_fill  = out_fill_reg;
    assign out_free  = out_free_reg;

endmodule

`default_nettype wire

[rtl/audio_frame_ring_fifo_top.sv]
// ---------------------------------------------------------------------------
// audio_frame_ring_fifo_top: ring fifo of signed 16-bit audio samples
// Push, frame pop, finish mark and clear over a streaming interface.
// ---------------------------------------------------------------------------
// Each transaction is accepted in a cycle in which the pointers update and
// the sample store is written or read; the emit state then takes the
// registered read of the store, whose two read ports fetch both samples of a
// stereo frame at once. The result sits in an output register, so the next
// transaction is accepted while the previous result waits; a new result is
// held back only while that register is still occupied. The ring holds at
// most DEPTH-1 samples; a push to a full ring is dropped and flagged. Store
// contents are not cleared by reset or by the clear operation.
`default_nettype none

module audio_frame_ring_fifo_top #(
    parameter int DEPTH = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: channel_count
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] sample_in
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] func
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] left_sample, [31:16] right_sample, [43:32] fill_level,
    // [55:44] free_space
    output logic [55:0]      m_axis_tdata,
    // [0] frame_valid, [1] write_dropped, [2] stream_ended
    output logic [2:0]       m_axis_tuser
);
    import afrf_pkg::*;

    localparam int PW = $clog2(DEPTH);

    logic               mem_we;
    logic [PW-1:0]      mem_waddr;
    sample_t            mem_wdata;
    logic               mem_re;
    logic [PW-1:0]      mem_raddr0;
    logic [PW-1:0]      mem_raddr1;
    sample_t            mem_rdata0;
    sample_t            mem_rdata1;

    sample_t            out_left;
    sample_t            out_right;
    res_flags_t         out_flags;
    logic [LEVEL_W-1:0] out_fill;
    logic [LEVEL_W-1:0] out_free;

    afrf_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_func    (func_t'(s_axis_tuser)),
        .in_sample  (sample_t'(s_axis_tdata)),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr0 (mem_raddr0),
        .mem_raddr1 (mem_raddr1),
        .mem_rdata0 (mem_rdata0),
        .mem_rdata1 (mem_rdata1),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_left   (out_left),
        .out_right  (out_right),
        .out_flags  (out_flags),
        .out_fill   (out_fill),
        .out_free   (out_free)
    );

    afrf_mem #(
        .DEPTH(DEPTH)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .re     (mem_re),
        .raddr0 (mem_raddr0),
        .raddr1 (mem_raddr1),
        .rdata0 (mem_rdata0),
        .rdata1 (mem_rdata1)
    );

    assign m_axis_tdata = {out_free, out_fill, out_right, out_left};
    assign m_axis_tuser = out_flags;

endmodule

`default_nettype wire
